// ===== rtl/core/kwc_pkg.sv =====
// kwc_pkg: shared constants, keyword table and item types of the keyword counter
// used by every file of the keyword_stream_counter block but kwc_ram
package kwc_pkg;

  // longest identifier and number of keywords that are counted
  localparam int MAX_WORD     = 64;
  localparam int NUM_KEYWORDS = 9;

  // keyword table geometry
  localparam int KEY_SLOTS = 16;
  localparam int KEY_CHARS = 8;
  localparam int CH_AW     = $clog2(KEY_CHARS);

  // widths derived from the constants above
  localparam int LEN_W    = $clog2(MAX_WORD + 1);
  localparam int KW_AW    = (NUM_KEYWORDS > 1) ? $clog2(NUM_KEYWORDS) : 1;
  localparam int KW_IW    = 4;
  localparam int COUNT_W  = 32;
  localparam int CHAR_W   = 8;

  // result queue depth, and the items the block holds at most
  localparam int Q_DEPTH = 2;

  localparam logic [KW_IW:0]   NUM_KW_W   = (KW_IW + 1)'(NUM_KEYWORDS);
  localparam logic [LEN_W-1:0] MAX_WORD_W = LEN_W'(MAX_WORD);
  localparam logic [LEN_W-1:0] KEY_CHARS_W = LEN_W'(KEY_CHARS);

  // keyword text, first character in the top byte
  localparam logic [KEY_CHARS*CHAR_W-1:0] KW_TEXT [KEY_SLOTS] = '{
    {"break", 24'h0}, {"case", 32'h0}, {"char", 32'h0}, {"const", 24'h0},
    "continue", {"define", 16'h0}, {"int", 40'h0}, {"void", 32'h0},
    {"return", 16'h0}, 64'h0, 64'h0, 64'h0, 64'h0, 64'h0, 64'h0, 64'h0
  };

  // keyword lengths, an empty slot never matches
  localparam logic [3:0] KW_LEN [KEY_SLOTS] = '{
    4'd5, 4'd4, 4'd4, 4'd5, 4'd8, 4'd6, 4'd3, 4'd4, 4'd6,
    4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0
  };

  // what the tokeniser hands to the counter stage for one item
  typedef struct packed {
    logic             is_read;
    logic             in_range;
    logic             word_done;
    logic             keyword_hit;
    logic [KW_IW-1:0] keyword_index;
  } kwc_req_t;

  // one result item
  typedef struct packed {
    logic               word_done;
    logic               keyword_hit;
    logic [KW_IW-1:0]   keyword_index;
    logic [COUNT_W-1:0] hit_count;
  } kwc_res_t;

endpackage

// ===== rtl/core/kwc_if.sv =====
// kwc_if: valid/ready stream interfaces for the text items and the result items
// depends on kwc_pkg for field widths
interface kwc_in_if;
  logic                      valid;
  logic                      ready;
  logic                      action;
  logic [kwc_pkg::CHAR_W-1:0] character;
  logic                      end_of_text;
  logic [kwc_pkg::KW_IW-1:0] query_index;

  modport source (output valid, action, character, end_of_text, query_index,
                  input ready);
  modport sink   (input valid, action, character, end_of_text, query_index,
                  output ready);
endinterface

interface kwc_out_if;
  logic                        valid;
  logic                        ready;
  logic                        word_done;
  logic                        keyword_hit;
  logic [kwc_pkg::KW_IW-1:0]   keyword_index;
  logic [kwc_pkg::COUNT_W-1:0] hit_count;

  modport source (output valid, word_done, keyword_hit, keyword_index, hit_count,
                  input ready);
  modport sink   (input valid, word_done, keyword_hit, keyword_index, hit_count,
                  output ready);
endinterface

// ===== rtl/core/kwc_ram.sv =====
// kwc_ram: generic single write port, single read port ram with registered read
// no dependencies
module kwc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, old data on a same-address write
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/kwc_tokenizer.sv =====
// kwc_tokenizer: identifier collection, word state and keyword compare
// depends on kwc_pkg for the keyword table and the request type
module kwc_tokenizer (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       fire,
  input  logic                       action,
  input  logic [kwc_pkg::CHAR_W-1:0] character,
  input  logic                       end_of_text,
  input  logic [kwc_pkg::KW_IW-1:0]  query_index,
  output kwc_pkg::kwc_req_t          req
);
  import kwc_pkg::*;

  logic [CHAR_W-1:0] word_chars [KEY_CHARS];
  logic [LEN_W-1:0]  word_length;
  logic [LEN_W-1:0]  word_length_next;
  logic [LEN_W-1:0]  len_inc;
  logic              in_word;
  logic              in_word_next;
  logic              ch_we;
  logic [CH_AW-1:0]  ch_idx;
  logic              is_letter;
  logic              is_digit;
  logic              match_hit;
  logic [KW_IW-1:0]  match_idx;
  logic [KEY_SLOTS-1:0] slot_eq;

  // parallel compare of the held word against every keyword
  always_comb begin
    slot_eq = '0;
    for (int i = 0; i < KEY_SLOTS; i++) begin
      if (i < NUM_KEYWORDS && KW_LEN[i] != 4'd0 && word_length == LEN_W'(KW_LEN[i])) begin
        slot_eq[i] = 1'b1;
        for (int j = 0; j < KEY_CHARS; j++) begin
          if (j < int'(KW_LEN[i]) &&
              word_chars[j] != KW_TEXT[i][KEY_CHARS*CHAR_W-1-CHAR_W*j -: CHAR_W]) begin
            slot_eq[i] = 1'b0;
          end
        end
      end
    end
  end

  // lowest matching slot wins
  always_comb begin
    match_hit = 1'b0;
    match_idx = '0;
    for (int i = KEY_SLOTS - 1; i >= 0; i--) begin
      if (slot_eq[i]) begin
        match_hit = 1'b1;
        match_idx = KW_IW'(i);
      end
    end
  end

  // character classes
  always_comb begin
    is_letter = (character >= "a" && character <= "z") ||
                (character >= "A" && character <= "Z");
    is_digit  = (character >= "0" && character <= "9");
  end

  assign len_inc = word_length + LEN_W'(1);

  // next word state and the request for this item
  always_comb begin
    req              = '0;
    in_word_next     = in_word;
    word_length_next = word_length;
    ch_we            = 1'b0;
    ch_idx           = '0;
    if (action) begin
      req.is_read       = 1'b1;
      req.keyword_index = query_index;
      req.in_range      = ({1'b0, query_index} < NUM_KW_W);
    end else if (end_of_text) begin
      if (in_word) begin
        req.word_done     = 1'b1;
        req.keyword_hit   = match_hit;
        req.keyword_index = match_idx;
        in_word_next      = 1'b0;
        word_length_next  = '0;
      end
    end else if (in_word) begin
      if (is_letter || is_digit) begin
        ch_we            = (word_length < KEY_CHARS_W);
        ch_idx           = word_length[CH_AW-1:0];
        word_length_next = len_inc;
        // a word at the length cap closes; it is too long for any keyword
        if (len_inc == MAX_WORD_W) begin
          req.word_done    = 1'b1;
          in_word_next     = 1'b0;
          word_length_next = '0;
        end
      end else begin
        req.word_done     = 1'b1;
        req.keyword_hit   = match_hit;
        req.keyword_index = match_idx;
        in_word_next      = 1'b0;
        word_length_next  = '0;
      end
    end else if (is_letter) begin
      ch_we            = 1'b1;
      ch_idx           = '0;
      word_length_next = LEN_W'(1);
      in_word_next     = 1'b1;
    end
  end

  // word control state
  always_ff @(posedge clk) begin
    if (rst) begin
      in_word     <= 1'b0;
      word_length <= '0;
    end else if (fire) begin
      in_word     <= in_word_next;
      word_length <= word_length_next;
    end
  end

  // held characters of the current word
  always_ff @(posedge clk) begin
    if (fire && ch_we) begin
      word_chars[ch_idx] <= character;
    end
  end

endmodule

// ===== rtl/core/kwc_counter.sv =====
// kwc_counter: keyword hit counters in a ram, read-modify-write with forwarding
// depends on kwc_pkg and kwc_ram
module kwc_counter (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  kwc_pkg::kwc_req_t req,
  output logic              res_valid,
  output kwc_pkg::kwc_res_t res
);
  import kwc_pkg::*;

  logic [KW_AW-1:0]       rd_addr;
  logic [COUNT_W-1:0]     rd_data;
  logic [(1<<KW_AW)-1:0]  entry_valid;

  logic                   s1_valid;
  kwc_req_t               s1_req;
  logic [KW_AW-1:0]       s1_addr;
  logic                   s1_entry_valid;
  logic                   s1_fwd;
  logic [COUNT_W-1:0]     s1_fwd_data;

  logic [COUNT_W-1:0]     base;
  logic [COUNT_W-1:0]     cnt_new;
  logic                   wr_en;

  assign rd_addr = req.keyword_index[KW_AW-1:0];

  kwc_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (NUM_KEYWORDS)
  ) u_count_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (s1_addr),
    .wdata (cnt_new),
    .re    (fire),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // read stage: capture the item, the entry's valid bit and any same-entry write
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      s1_req         <= req;
      s1_addr        <= rd_addr;
      s1_entry_valid <= entry_valid[rd_addr];
      s1_fwd         <= wr_en && (s1_addr == rd_addr);
      s1_fwd_data    <= cnt_new;
    end
  end

  // update stage: pick the current count, saturating increment
  always_comb begin
    if (s1_fwd) begin
      base = s1_fwd_data;
    end else if (s1_entry_valid) begin
      base = rd_data;
    end else begin
      base = '0;
    end
    cnt_new = (base == '1) ? base : base + COUNT_W'(1);
    wr_en   = s1_valid && s1_req.keyword_hit;
  end

  // counters never written read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (wr_en) begin
      entry_valid[s1_addr] <= 1'b1;
    end
  end

  // result of the item in the update stage
  always_comb begin
    res_valid         = s1_valid;
    res.word_done     = s1_req.word_done;
    res.keyword_hit   = s1_req.keyword_hit;
    res.keyword_index = s1_req.keyword_index;
    if (s1_req.keyword_hit) begin
      res.hit_count = cnt_new;
    end else if (s1_req.is_read && s1_req.in_range) begin
      res.hit_count = base;
    end else begin
      res.hit_count = '0;
    end
  end

endmodule

// ===== rtl/core/kwc_out_queue.sv =====
// kwc_out_queue: two-entry result queue between the counter stage and the output
// depends on kwc_pkg for the result type
module kwc_out_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  kwc_pkg::kwc_res_t push_data,
  input  logic              pop,
  output logic              head_valid,
  output kwc_pkg::kwc_res_t head_data,
  output logic [1:0]        count
);
  import kwc_pkg::*;

  kwc_res_t slots [Q_DEPTH];
  logic     wr_ptr;
  logic     rd_ptr;

  assign head_valid = (count != 2'd0);
  assign head_data  = slots[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== rtl/core/keyword_stream_counter_top.sv =====
// keyword_stream_counter_top: top level of the keyword counting tokeniser
// depends on kwc_pkg, kwc_if, kwc_tokenizer, kwc_counter, kwc_out_queue
//
// usage
//   stream carries one text item per handshake: a byte with action 0, an
//   end_of_text flag that closes a pending word, or a counter read with
//   action 1 and query_index. every item gives exactly one result item on
//   result: word_done, keyword_hit, keyword_index and hit_count.
//   identifiers are matched in the accept cycle against nine keywords in
//   parallel; the hit counters live in a ram and are updated by a
//   read-modify-write in the cycle after, with forwarding between back-to-back
//   hits on the same keyword.
//   a result passes from the update stage register into the result queue,
//   and the queue offers it on result.
//   throughput: one item per cycle while stream.ready is high, set by the single counter ram port pair.
//   reset (rst, synchronous): word state and counters read as zero at once,
//   no clearing pass; the queue empties and ready rises after reset.
//   stall: a two-entry result queue holds finished items; stream.ready stays
//   high while the block holds fewer than two items or a result is taken.
module keyword_stream_counter_top (
  input  logic       clk,
  input  logic       rst,
  kwc_in_if.sink     stream,
  kwc_out_if.source  result
);
  import kwc_pkg::*;

  logic       in_fire;
  logic       out_fire;
  kwc_req_t   req;
  logic       res_valid;
  kwc_res_t   res;
  kwc_res_t   head_data;
  logic       head_valid;
  logic [1:0] q_count;
  logic [1:0] held;

  assign in_fire  = stream.valid && stream.ready;
  assign out_fire = result.valid && result.ready;

  // items in the update stage plus items waiting in the queue
  assign held         = q_count + 2'(res_valid);
  assign stream.ready = !rst && ((held < 2'(Q_DEPTH)) || out_fire);

  kwc_tokenizer u_tokenizer (
    .clk         (clk),
    .rst         (rst),
    .fire        (in_fire),
    .action      (stream.action),
    .character   (stream.character),
    .end_of_text (stream.end_of_text),
    .query_index (stream.query_index),
    .req         (req)
  );

  kwc_counter u_counter (
    .clk       (clk),
    .rst       (rst),
    .fire      (in_fire),
    .req       (req),
    .res_valid (res_valid),
    .res       (res)
  );

  kwc_out_queue u_out_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (res_valid),
    .push_data  (res),
    .pop        (out_fire),
    .head_valid (head_valid),
    .head_data  (head_data),
    .count      (q_count)
  );

  // result port
  assign result.valid         = head_valid;
  assign result.word_done     = head_data.word_done;
  assign result.keyword_hit   = head_data.keyword_hit;
  assign result.keyword_index = head_data.keyword_index;
  assign result.hit_count     = head_data.hit_count;

endmodule

// ===== rtl/core/kwc_checker.sv =====
// kwc_checker: port-level assertions for keyword_stream_counter_top, and its bind
// depends on kwc_pkg for field widths
module kwc_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        word_done,
  input logic                        keyword_hit,
  input logic [kwc_pkg::KW_IW-1:0]   keyword_index,
  input logic [kwc_pkg::COUNT_W-1:0] hit_count
);
  import kwc_pkg::*;

  logic [2:0] pend;

  // items accepted whose result is not yet taken
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 3'd0;
    end else begin
      pend <= pend + 3'(in_valid && in_ready) - 3'(out_valid && out_ready);
    end
  end

  // no result without an item behind it
  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pend != 3'd0)
    else $error("result item without an accepted item");

  // the block never holds more than its queue allows
  a_bounded: assert property (@(posedge clk) disable iff (rst)
    pend <= 3'(Q_DEPTH))
    else $error("more items held than the result queue allows");

  // a keyword hit only on a closed word, and its count is at least one
  a_hit_closed: assert property (@(posedge clk) disable iff (rst)
    out_valid && keyword_hit |-> word_done && hit_count != '0)
    else $error("keyword hit without a closed word or with zero count");

  // a hit names a counted keyword
  a_hit_index: assert property (@(posedge clk) disable iff (rst)
    out_valid && keyword_hit |-> {1'b0, keyword_index} < NUM_KW_W)
    else $error("keyword hit with an index beyond the table");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(hit_count) &&
      $stable(keyword_index) && $stable(word_done) && $stable(keyword_hit))
    else $error("stalled result item changed");

endmodule

bind keyword_stream_counter_top kwc_checker u_kwc_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (stream.valid),
  .in_ready      (stream.ready),
  .out_valid     (result.valid),
  .out_ready     (result.ready),
  .word_done     (result.word_done),
  .keyword_hit   (result.keyword_hit),
  .keyword_index (result.keyword_index),
  .hit_count     (result.hit_count)
);

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// testbench: self-checking bench for keyword_stream_counter_top
// depends on kwc_pkg and kwc_if; keeps its own tokeniser and hit counters to predict results
module testbench;
  import kwc_pkg::*;

  localparam logic ACT_TEXT     = 1'b0;
  localparam logic ACT_READ     = 1'b1;
  localparam int   STALL_LIMIT  = 5000;
  localparam int   DRAIN_CYCLES = 6;
  localparam int   TABLE_SIZE   = 9;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CASE_BIT = 8'h20;

  logic clk = 1'b0;
  logic rst = 1'b1;

  kwc_in_if  stream ();
  kwc_out_if result ();

  keyword_stream_counter_top i_dut (
    .clk    (clk),
    .rst    (rst),
    .stream (stream),
    .result (result)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state: open identifier and per-keyword hit counters
  string              keyword_text [TABLE_SIZE] = '{"break", "case", "char", "const",
                                                    "continue", "define", "int", "void",
                                                    "return"};
  logic [7:0]         word_head [KEY_CHARS];
  int                 word_len  = 0;
  bit                 word_open = 1'b0;
  logic [COUNT_W-1:0] keyword_hits [NUM_KEYWORDS] = '{default: '0};

  kwc_res_t expected_results [$];
  kwc_res_t oldest_res;
  int       send_idle_pct  = 0;
  int       recv_stall_pct = 0;
  int       error_count    = 0;
  int       idle_cycles    = 0;
  int       items_sent     = 0;

  function automatic bit is_alpha(logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
  endfunction

  function automatic bit is_num(logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  // close the open identifier and look it up in the keyword table
  function automatic kwc_res_t close_open_word();
    kwc_res_t r;
    bit       same;
    r = '0;
    r.word_done = 1'b1;
    for (int k = 0; k < NUM_KEYWORDS && k < TABLE_SIZE; k++) begin
      if (!r.keyword_hit && word_len == keyword_text[k].len()) begin
        same = 1'b1;
        for (int j = 0; j < word_len; j++)
          if (word_head[j] != keyword_text[k][j]) same = 1'b0;
        if (same) begin
          if (keyword_hits[k] != '1) keyword_hits[k]++;
          r.keyword_hit   = 1'b1;
          r.keyword_index = KW_IW'(k);
          r.hit_count     = keyword_hits[k];
        end
      end
    end
    word_open = 1'b0;
    word_len  = 0;
    return r;
  endfunction

  // expected result of one accepted item, advancing the tokeniser state
  function automatic kwc_res_t predict_result(logic act, logic [7:0] ch, logic eot,
                                              logic [KW_IW-1:0] q);
    kwc_res_t r;
    r = '0;
    if (act == ACT_READ) begin
      r.keyword_index = q;
      if (q < NUM_KEYWORDS) r.hit_count = keyword_hits[q];
    end else if (eot) begin
      if (word_open) r = close_open_word();
    end else if (word_open) begin
      if (is_alpha(ch) || is_num(ch)) begin
        if (word_len < KEY_CHARS) word_head[word_len] = ch;
        word_len++;
        if (word_len >= MAX_WORD) r = close_open_word();
      end else begin
        r = close_open_word();
      end
    end else if (is_alpha(ch)) begin
      word_head[0] = ch;
      word_len     = 1;
      word_open    = 1'b1;
      if (word_len >= MAX_WORD) r = close_open_word();
    end
    return r;
  endfunction

  // predict on acceptance, compare on result, watch for a hung handshake
  always @(posedge clk) begin
    if (!rst) begin
      if (stream.valid && stream.ready)
        expected_results.push_back(predict_result(stream.action, stream.character,
                                                  stream.end_of_text, stream.query_index));
      if (result.valid && result.ready) begin
        if (expected_results.size() == 0) begin
          $error("result item with no expectation pending");
          error_count++;
        end else begin
          oldest_res = expected_results.pop_front();
          if (result.word_done !== oldest_res.word_done) begin
            $error("word_done expected %0d got %0d", oldest_res.word_done, result.word_done);
            error_count++;
          end
          if (result.keyword_hit !== oldest_res.keyword_hit) begin
            $error("keyword_hit expected %0d got %0d", oldest_res.keyword_hit,
                   result.keyword_hit);
            error_count++;
          end
          if (result.keyword_index !== oldest_res.keyword_index) begin
            $error("keyword_index expected %0d got %0d", oldest_res.keyword_index,
                   result.keyword_index);
            error_count++;
          end
          if (result.hit_count !== oldest_res.hit_count) begin
            $error("hit_count expected %0d got %0d", oldest_res.hit_count,
                   result.hit_count);
            error_count++;
          end
        end
      end
      if ((stream.valid && stream.ready) || (result.valid && result.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("keyword_stream_counter_top verification failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // result back-pressure
  always @(negedge clk) begin
    result.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // drive one item and hold it until accepted
  task automatic send_item(logic act, logic [7:0] ch, logic eot, logic [KW_IW-1:0] q);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      stream.valid <= 1'b0;
      @(negedge clk);
    end
    stream.valid       <= 1'b1;
    stream.action      <= act;
    stream.character   <= ch;
    stream.end_of_text <= eot;
    stream.query_index <= q;
    @(posedge clk);
    while (!stream.ready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_char(logic [7:0] c);
    send_item(ACT_TEXT, c, 1'b0, KW_IW'($urandom_range(0, 15)));
  endtask

  task automatic send_eot();
    send_item(ACT_TEXT, 8'($urandom_range(0, 255)), 1'b1, KW_IW'($urandom_range(0, 15)));
  endtask

  task automatic send_read(logic [KW_IW-1:0] q);
    send_item(ACT_READ, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), q);
  endtask

  task automatic send_word(string s);
    for (int j = 0; j < s.len(); j++) send_char(s[j]);
  endtask

  function automatic logic [7:0] rand_letter();
    return $urandom_range(0, 1) ? 8'($urandom_range(8'h61, 8'h7a))
                                : 8'($urandom_range(8'h41, 8'h5a));
  endfunction

  function automatic logic [7:0] rand_alnum();
    return ($urandom_range(0, 3) == 0) ? 8'($urandom_range(8'h30, 8'h39)) : rand_letter();
  endfunction

  // space, nul, another non-alphanumeric ascii byte or a byte above 127
  function automatic logic [7:0] rand_delimiter();
    logic [7:0] c;
    case ($urandom_range(0, 3))
      0: c = CH_SPACE;
      1: c = CH_NUL;
      2: begin
        c = 8'($urandom_range(0, 127));
        while (is_alpha(c) || is_num(c)) c = 8'($urandom_range(0, 127));
      end
      default: c = 8'($urandom_range(128, 255));
    endcase
    return c;
  endfunction

  // every keyword once, one twice, closed by space and end of text
  task automatic test_keyword_table();
    for (int k = 0; k < TABLE_SIZE; k++) begin
      send_word(keyword_text[k]);
      send_char(CH_SPACE);
    end
    send_word("int");
    send_eot();
  endtask

  // closing bytes of every kind, case sensitivity, digits outside a word
  task automatic test_delimiters();
    send_word("break");
    send_char(8'hff);
    send_word("void");
    send_char(CH_NUL);
    send_word("Int.");
    send_word("7x9");
    send_eot();
    send_eot();
    send_word("char1 ");
  endtask

  // a word reaching the length cap closes itself, the next byte starts afresh
  task automatic test_long_word();
    send_char(8'h61);
    for (int j = 1; j < MAX_WORD; j++) send_char((j % 3 == 0) ? 8'h39 : 8'h5a);
    send_word("case");
    send_eot();
    for (int j = 0; j < MAX_WORD - 1; j++) send_char(8'h7a);
    send_char(CH_SPACE);
  endtask

  // every query index, in and out of the table
  task automatic test_counter_reads();
    for (int q = 0; q < 16; q++) send_read(KW_IW'(q));
  endtask

  // mostly keywords and near misses, with identifiers, reads and noise between
  task automatic test_random_stream(int n);
    int         start;
    int         kind;
    int         k;
    int         len;
    logic [7:0] spell [$];
    start = items_sent;
    while (items_sent - start < n) begin
      spell = {};
      kind  = $urandom_range(0, 99);
      k     = $urandom_range(0, TABLE_SIZE - 1);
      if (kind < 58) begin
        for (int j = 0; j < keyword_text[k].len(); j++) spell.push_back(keyword_text[k][j]);
        if (kind < 45) begin
          if ($urandom_range(0, 9) == 0)
            spell[$urandom_range(0, spell.size() - 1)] ^= CASE_BIT;
        end else begin
          case ($urandom_range(0, 2))
            0: spell.push_back(rand_alnum());
            1: void'(spell.pop_back());
            default: spell.push_front(rand_letter());
          endcase
        end
      end else if (kind < 74) begin
        len = (kind < 72) ? $urandom_range(1, 12) : $urandom_range(MAX_WORD - 2, MAX_WORD + 6);
        spell.push_back(rand_letter());
        for (int j = 1; j < len; j++) spell.push_back(rand_alnum());
      end else if (kind < 84) begin
        send_read(KW_IW'($urandom_range(0, 15)));
      end else if (kind < 89) begin
        send_eot();
      end else begin
        send_char(8'($urandom_range(0, 255)));
      end
      foreach (spell[j]) send_char(spell[j]);
      // close the word, or now and then run straight into the next one
      if (spell.size() != 0) begin
        kind = $urandom_range(0, 99);
        if (kind < 15) send_eot();
        else if (kind < 92) send_char(rand_delimiter());
      end
    end
  endtask

  initial begin
    stream.valid       = 1'b0;
    stream.action      = ACT_TEXT;
    stream.character   = '0;
    stream.end_of_text = 1'b0;
    stream.query_index = '0;
    result.ready       = 1'b0;
    send_idle_pct      = 17;
    recv_stall_pct     = 48;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_keyword_table();
    test_delimiters();
    test_long_word();
    test_counter_reads();
    test_random_stream(530);
    send_idle_pct  = 48;
    recv_stall_pct = 17;
    test_random_stream(530);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_random_stream(530);
    test_counter_reads();
    stream.valid <= 1'b0;

    // drain outstanding results, then allow for the pipeline depth
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("keyword_stream_counter_top verification clean");
    end else begin
      $display("keyword_stream_counter_top verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/kwc_pkg.sv
rtl/core/kwc_if.sv
rtl/core/kwc_ram.sv
rtl/core/kwc_tokenizer.sv
rtl/core/kwc_counter.sv
rtl/core/kwc_out_queue.sv
rtl/core/keyword_stream_counter_top.sv
rtl/core/kwc_checker.sv
dv/testbench.sv
